@@ hw/rtl/bvkd_pkg.sv @@
// bvkd_pkg: shared codes and types for the bounded keyed deque.
// Depends on nothing; imported by the cell and the top level.
`timescale 1ns / 1ps
package bvkd_pkg;
    // action codes
    localparam logic [3:0] ACT_PUSH_FRONT = 4'd0;
    localparam logic [3:0] ACT_PUSH_BACK  = 4'd1;
    localparam logic [3:0] ACT_INS_BEFORE = 4'd2;
    localparam logic [3:0] ACT_INS_AFTER  = 4'd3;
    localparam logic [3:0] ACT_REMOVE_KEY = 4'd4;
    localparam logic [3:0] ACT_POP_FRONT  = 4'd5;
    localparam logic [3:0] ACT_POP_BACK   = 4'd6;
    localparam logic [3:0] ACT_LIST_FWD   = 4'd7;
    localparam logic [3:0] ACT_LIST_BWD   = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // cell commands
    localparam logic [2:0] CELL_HOLD  = 3'd0;
    localparam logic [2:0] CELL_LEFT  = 3'd1;
    localparam logic [2:0] CELL_RIGHT = 3'd2;
    localparam logic [2:0] CELL_LOAD  = 3'd3;
    localparam logic [2:0] CELL_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0] code;
        logic       pre_clr;
        logic       pre_step;
    } t_cell_ctl;
endpackage

@@ hw/rtl/bvkd_channels.sv @@
// Request and response channel interfaces of the keyed deque.
// Depends on nothing.
`timescale 1ns / 1ps
interface bvkd_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic signed [31:0] item_value;
    logic signed [31:0] key_value;
    modport source (output valid, action, item_value, key_value, input ready);
    modport sink   (input valid, action, item_value, key_value, output ready);
endinterface

interface bvkd_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_value;
    logic [1:0]  status;
    logic        last;
    modport source (output valid, out_value, status, last, input ready);
    modport sink   (input valid, out_value, status, last, output ready);
endinterface

@@ hw/rtl/bvkd_cell.sv @@
// bvkd_cell: one list position: value, valid flag and key-search prefix flag.
// Depends on bvkd_pkg.
`timescale 1ns / 1ps
module bvkd_cell import bvkd_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [VALUE_BITS-1:0] i_load_value,
    input  logic [VALUE_BITS-1:0] i_key,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic                  i_left_valid,
    input  logic                  i_left_pre,
    input  logic                  i_left_match,
    input  logic [VALUE_BITS-1:0] i_right_value,
    input  logic                  i_right_valid,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_valid,
    output logic                  o_pre,
    output logic                  o_match
);
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic                  r_valid, n_valid;
    logic                  r_pre;

    // next value and valid from the command
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        case (i_ctl.code)
            CELL_LEFT: begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end
            CELL_RIGHT: begin
                n_value = i_right_value;
                n_valid = i_right_valid;
            end
            CELL_LOAD: begin
                n_value = i_load_value;
                n_valid = 1'b1;
            end
            CELL_CLEAR: n_valid = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // valid and prefix flag: prefix = some match strictly to the left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pre   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.pre_clr) begin
                r_pre <= 1'b0;
            end else if (i_ctl.pre_step) begin
                r_pre <= i_left_pre | i_left_match;
            end
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_pre   = r_pre;
    assign o_match = r_valid && (r_value == i_key);
endmodule

@@ hw/rtl/bounded_value_keyed_deque_core.sv @@
// Keyed deque: a row of CAPACITY cells holding the list in order, front at cell 0.
// Push and pop complete in S_EXEC; keyed actions first run a key search (S_SRCH,
// then S_KEY) that shifts a prefix flag one cell per cycle; listing emits one
// entry per cycle unless the response stalls. One request is handled at a time.
// Reset (synchronous, active low) empties the list; no clearing pass is needed.
`timescale 1ns / 1ps
module bounded_value_keyed_deque_core import bvkd_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bvkd_req_if.sink   i_req,
    bvkd_rsp_if.source o_rsp
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_KEY  = 3'd3;
    localparam logic [2:0] S_LIST = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [3:0]            r_act;
    logic [VALUE_BITS-1:0] r_item, r_key, c_in_item, c_in_key;
    logic [CW-1:0]         r_count, n_count, r_remain, n_remain;
    logic [IW-1:0]         r_step, n_step;
    logic                  r_ov, n_ov;
    logic [31:0]           r_oval, n_oval, c_emit32;
    logic [1:0]            r_ost, n_ost;
    logic                  r_olast, n_olast;

    // cell row signals
    t_cell_ctl             c_ctl   [CAPACITY];
    logic [VALUE_BITS-1:0] c_val   [CAPACITY];
    logic                  c_vld   [CAPACITY];
    logic                  c_pre   [CAPACITY];
    logic                  c_mat   [CAPACITY];
    logic                  c_tail  [CAPACITY];
    logic [VALUE_BITS-1:0] c_tailv [CAPACITY];
    logic [VALUE_BITS-1:0] c_load, c_emit;
    logic                  c_found;

    // operation selects for the row
    logic op_front, op_back, op_before, op_after, op_remove;
    logic op_popf, op_popb, op_rotl, op_rotr, op_pre_clr, op_pre_step;

    // value width adaptation at the ports
    generate
        if (VALUE_BITS > 32) begin : g_wide
            assign c_in_item = {{(VALUE_BITS-32){i_req.item_value[31]}}, i_req.item_value};
            assign c_in_key  = {{(VALUE_BITS-32){i_req.key_value[31]}}, i_req.key_value};
            assign c_emit32  = c_emit[31:0];
        end else if (VALUE_BITS == 32) begin : g_same
            assign c_in_item = i_req.item_value;
            assign c_in_key  = i_req.key_value;
            assign c_emit32  = c_emit;
        end else begin : g_narrow
            assign c_in_item = i_req.item_value[VALUE_BITS-1:0];
            assign c_in_key  = i_req.key_value[VALUE_BITS-1:0];
            assign c_emit32  = {{(32-VALUE_BITS){1'b0}}, c_emit};
        end
    endgenerate

    // cell row with neighbor wiring
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic [VALUE_BITS-1:0] w_lv, w_rv;
            logic                  w_lvld, w_lpre, w_lmat, w_rvld;
            if (i == 0) begin : g_first
                assign w_lv = '0;
                assign w_lvld = 1'b0;
                assign w_lpre = 1'b0;
                assign w_lmat = 1'b0;
            end else begin : g_mid
                assign w_lv = c_val[i-1];
                assign w_lvld = c_vld[i-1];
                assign w_lpre = c_pre[i-1];
                assign w_lmat = c_mat[i-1];
            end
            if (i == CAPACITY - 1) begin : g_end
                assign w_rv = '0;
                assign w_rvld = 1'b0;
            end else begin : g_inner
                assign w_rv = c_val[i+1];
                assign w_rvld = c_vld[i+1];
            end
            assign c_tail[i]  = c_vld[i] && !w_rvld;
            assign c_tailv[i] = c_tail[i] ? c_val[i] : '0;

            bvkd_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (c_ctl[i]),
                .i_load_value  (c_load),
                .i_key         (r_key),
                .i_left_value  (w_lv),
                .i_left_valid  (w_lvld),
                .i_left_pre    (w_lpre),
                .i_left_match  (w_lmat),
                .i_right_value (w_rv),
                .i_right_valid (w_rvld),
                .o_value       (c_val[i]),
                .o_valid       (c_vld[i]),
                .o_pre         (c_pre[i]),
                .o_match       (c_mat[i])
            );
        end
    endgenerate

    // tail value (one-hot OR) and any-match flag
    logic [VALUE_BITS-1:0] c_tail_value;
    always_comb begin
        c_tail_value = '0;
        c_found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            c_tail_value = c_tail_value | c_tailv[i];
            c_found = c_found | c_mat[i];
        end
    end

    assign c_load = op_rotl ? c_val[0] : (op_rotr ? c_tail_value : r_item);
    assign c_emit = (r_act == ACT_LIST_BWD) ? c_tail_value : c_val[0];

    // per-cell commands
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            logic lvld, lpre, first;
            lvld  = (i == 0) ? 1'b0 : c_vld[(i > 0) ? i - 1 : 0];
            lpre  = (i == 0) ? 1'b0 : c_pre[(i > 0) ? i - 1 : 0];
            first = c_mat[i] && !c_pre[i];
            c_ctl[i].code     = CELL_HOLD;
            c_ctl[i].pre_clr  = op_pre_clr;
            c_ctl[i].pre_step = op_pre_step;
            if (op_front) begin
                c_ctl[i].code = (i == 0) ? CELL_LOAD : CELL_LEFT;
            end else if (op_back) begin
                if (!c_vld[i] && ((i == 0) || lvld)) c_ctl[i].code = CELL_LOAD;
            end else if (op_before) begin
                if (first) c_ctl[i].code = CELL_LOAD;
                else if (c_pre[i]) c_ctl[i].code = CELL_LEFT;
            end else if (op_after) begin
                if (lpre) c_ctl[i].code = CELL_LEFT;
                else if (c_pre[i]) c_ctl[i].code = CELL_LOAD;
            end else if (op_remove) begin
                if (c_pre[i] || c_mat[i]) c_ctl[i].code = CELL_RIGHT;
            end else if (op_popf) begin
                c_ctl[i].code = CELL_RIGHT;
            end else if (op_popb) begin
                if (c_tail[i]) c_ctl[i].code = CELL_CLEAR;
            end else if (op_rotl) begin
                if (c_tail[i]) c_ctl[i].code = CELL_LOAD;
                else if (c_vld[i]) c_ctl[i].code = CELL_RIGHT;
            end else if (op_rotr) begin
                if (i == 0) c_ctl[i].code = CELL_LOAD;
                else if (c_vld[i]) c_ctl[i].code = CELL_LEFT;
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_ov;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_remain = r_remain;
        n_step   = r_step;
        n_ov     = r_ov && !o_rsp.ready;
        n_oval   = r_oval;
        n_ost    = r_ost;
        n_olast  = r_olast;
        op_front = 1'b0; op_back = 1'b0; op_before = 1'b0; op_after = 1'b0;
        op_remove = 1'b0; op_popf = 1'b0; op_popb = 1'b0;
        op_rotl = 1'b0; op_rotr = 1'b0; op_pre_clr = 1'b0; op_pre_step = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_ov = 1'b1; n_oval = '0; n_ost = ST_OK; n_olast = 1'b1;
                case (r_act)
                    ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INS_BEFORE, ACT_INS_AFTER: begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_ost = ST_FULL;
                        end else if (r_count == '0 || r_act == ACT_PUSH_BACK) begin
                            op_back = 1'b1;
                            n_count = r_count + 1'b1;
                        end else if (r_act == ACT_PUSH_FRONT) begin
                            op_front = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_ov = 1'b0; op_pre_clr = 1'b1;
                            n_step = '0; n_state = S_SRCH;
                        end
                    end
                    ACT_REMOVE_KEY, ACT_POP_FRONT, ACT_POP_BACK: begin
                        if (r_count == '0) begin
                            n_ost = ST_EMPTY;
                        end else if (r_act == ACT_REMOVE_KEY) begin
                            n_ov = 1'b0; op_pre_clr = 1'b1;
                            n_step = '0; n_state = S_SRCH;
                        end else begin
                            op_popf = (r_act == ACT_POP_FRONT);
                            op_popb = (r_act == ACT_POP_BACK);
                            n_count = r_count - 1'b1;
                        end
                    end
                    ACT_LIST_FWD, ACT_LIST_BWD: begin
                        if (r_count == '0) begin
                            n_ost = ST_EMPTY;
                        end else begin
                            n_ov = 1'b0; n_remain = r_count; n_state = S_LIST;
                        end
                    end
                    default: ;
                endcase
            end
            S_SRCH: begin
                op_pre_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == IW'(CAPACITY - 2)) n_state = S_KEY;
            end
            S_KEY: begin
                n_state = S_IDLE;
                n_ov = 1'b1; n_oval = '0; n_ost = ST_OK; n_olast = 1'b1;
                if (!c_found) begin
                    n_ost = ST_NOT_FOUND;
                end else if (r_act == ACT_REMOVE_KEY) begin
                    op_remove = 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    op_before = (r_act == ACT_INS_BEFORE);
                    op_after  = (r_act == ACT_INS_AFTER);
                    n_count = r_count + 1'b1;
                end
            end
            S_LIST: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov = 1'b1; n_oval = c_emit32; n_ost = ST_OK;
                    n_olast = (r_remain == CW'(1));
                    op_rotl = (r_act == ACT_LIST_FWD);
                    op_rotr = (r_act == ACT_LIST_BWD);
                    n_remain = r_remain - 1'b1;
                    if (r_remain == CW'(1)) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_remain <= '0;
            r_step   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_step   <= n_step;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_act  <= i_req.action;
            r_item <= c_in_item;
            r_key  <= c_in_key;
        end
        r_oval  <= n_oval;
        r_ost   <= n_ost;
        r_olast <= n_olast;
    end

    assign o_rsp.valid     = r_ov;
    assign o_rsp.out_value = r_oval;
    assign o_rsp.status    = r_ost;
    assign o_rsp.last      = r_olast;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("entry count above capacity");
    a_front_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_vld[0] == (r_count != '0)) else $error("front cell disagrees with count");
    a_list_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_remain != '0)) else $error("listing with nothing left");
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_EXEC)) else $error("accept lost");
endmodule
